// ===== hdl/lfbws_pkg.sv =====
`timescale 1ns / 1ps

package lfbws_pkg;

    // Fixed field widths
    localparam int COORD_W     = 6;
    localparam int CHAN_W      = 8;
    localparam int SYMBOL_BITS = 4;
    localparam int SYMS_W      = CHAN_W * SYMBOL_BITS;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = SYMBOL_BITS;

    // Framebuffer storage
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Default matrix geometry
    localparam int DEF_COLUMNS = 8;
    localparam int DEF_ROWS    = 8;

    // Register reset values
    localparam logic [SYMBOL_BITS-1:0] SYM_ONE_RST  = 4'd14;
    localparam logic [SYMBOL_BITS-1:0] SYM_ZERO_RST = 4'd8;
    localparam logic [CHAN_W-1:0]      BRIGHT_RST   = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW     = 2'd0,
        CMD_FILL     = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_TRANSMIT = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYM_ONE  = 1'b0,
        CFG_SYM_ZERO = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    // Channel order of the shared scaler pass
    typedef enum logic [1:0] {
        CH_GREEN = 2'd0,
        CH_RED   = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // One framebuffer word
    typedef struct packed {
        logic [CHAN_W-1:0] bright;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    // Result item held in the output register
    typedef struct packed {
        logic [COORD_W-1:0] pixel_index;
        logic [SYMS_W-1:0]  green_symbols;
        logic [SYMS_W-1:0]  red_symbols;
        logic [SYMS_W-1:0]  blue_symbols;
        logic               last_pixel;
    } t_result;

    // Expand a byte into symbols, MSB symbol in the top nibble
    function automatic logic [SYMS_W-1:0] expand_byte(
        input logic [CHAN_W-1:0]      v,
        input logic [SYMBOL_BITS-1:0] sym_one,
        input logic [SYMBOL_BITS-1:0] sym_zero
    );
        logic [SYMS_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < CHAN_W; b++) begin
            acc[b*SYMBOL_BITS +: SYMBOL_BITS] = v[b] ? sym_one : sym_zero;
        end
        return acc;
    endfunction

endpackage

// ===== hdl/lfbws_cmd_if.sv =====
`timescale 1ns / 1ps

interface lfbws_cmd_if;
    import lfbws_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  brightness;

    modport source (
        output valid, cmd, column, row, red, green, blue, brightness,
        input  ready
    );

    modport sink (
        input  valid, cmd, column, row, red, green, blue, brightness,
        output ready
    );
endinterface

// ===== hdl/lfbws_pix_if.sv =====
`timescale 1ns / 1ps

interface lfbws_pix_if;
    import lfbws_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_index;
    logic [SYMS_W-1:0]  green_symbols;
    logic [SYMS_W-1:0]  red_symbols;
    logic [SYMS_W-1:0]  blue_symbols;
    logic               last_pixel;

    modport source (
        output valid, pixel_index, green_symbols, red_symbols, blue_symbols, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_index, green_symbols, red_symbols, blue_symbols, last_pixel,
        output ready
    );
endinterface

// ===== hdl/led_framebuffer_ws2812_encoder_core.sv =====
`timescale 1ns / 1ps

// Channel      Dir  Handshake          Contents
// i_cmd_req    in   valid/ready        cmd, column, row, red, green, blue, brightness
// o_pix_req    out  valid/ready        pixel_index, green/red/blue symbols, last_pixel
// i_cfg_*      in   write enable only  index 0 symbol for one, index 1 symbol for zero
//
// Draw, fill and clear are applied when accepted; fill and clear retag the whole
// framebuffer at once through per-entry valid bits and a fill word.
// Transmit walks each pixel through one RAM read, then the single shared
// 8x8 multiplier and divide-by-255 stage run once per channel (S_MUL then
// S_DIV), then the output register is loaded. A stalled output holds the walk.
// Synchronous reset clears the valid bits, so no clearing pass is needed.

module led_framebuffer_ws2812_encoder_core #(
    parameter int COLUMNS = lfbws_pkg::DEF_COLUMNS,
    parameter int ROWS    = lfbws_pkg::DEF_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lfbws_cmd_if.sink                        i_cmd_req,
    lfbws_pix_if.source                      o_pix_req,
    input  logic                             i_cfg_we,
    input  logic [lfbws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfbws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lfbws_pkg::*;

    localparam int CHAIN_RAW = COLUMNS * ROWS;
    localparam int CHAIN_LEN = (CHAIN_RAW > STORE_DEPTH) ? STORE_DEPTH : CHAIN_RAW;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CHAIN_LEN - 1);
    localparam int POS_W = 2 * COORD_W + 1;

    // State and registers
    t_state                 r_state, n_state;
    logic [SYMBOL_BITS-1:0] r_sym_one, r_sym_zero;
    logic [STORE_DEPTH-1:0] r_valid;
    t_pixel                 r_fill;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_rd_valid;
    t_chan                  r_ch;
    logic [CHAN_W-1:0]      r_sg, r_sr, r_sb;
    t_result                r_out;
    logic                   r_out_valid;

    // Combinational
    logic              w_accept;
    t_cmd              w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic              w_draw_ok;
    t_pixel            w_in_pix;
    t_pixel            w_pix;
    logic [PIXEL_W-1:0] w_rdata;
    logic [CHAN_W-1:0] w_chan;
    logic [CHAN_W-1:0] w_quot;
    logic              w_out_free;
    logic              w_in_ready;
    logic              w_ram_re;
    logic              w_mul_start;
    logic              w_load_out;
    logic              w_ram_we;

    assign w_cmd    = t_cmd'(i_cmd_req.cmd);
    assign w_accept = i_cmd_req.valid && w_in_ready;

    assign w_in_pix = '{bright: i_cmd_req.brightness, red: i_cmd_req.red,
                        green: i_cmd_req.green, blue: i_cmd_req.blue};

    // Serpentine chain position of a draw
    always_comb begin
        logic [POS_W-1:0] col_off;
        col_off = i_cmd_req.row[0]
                ? POS_W'(COLUMNS - 1) - POS_W'(i_cmd_req.column)
                : POS_W'(i_cmd_req.column);
        w_pos = POS_W'(i_cmd_req.row) * POS_W'(COLUMNS) + col_off;
        w_draw_ok = (POS_W'(i_cmd_req.column) < POS_W'(COLUMNS))
                 && (POS_W'(i_cmd_req.row) < POS_W'(ROWS))
                 && (w_pos < POS_W'(STORE_DEPTH));
    end

    assign w_ram_we = w_accept && (w_cmd == CMD_DRAW) && w_draw_ok;

    lfbws_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_pos[ADDR_W-1:0]),
        .i_wdata (w_in_pix),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Unwritten entries read as the last fill word
    assign w_pix = r_rd_valid ? t_pixel'(w_rdata) : r_fill;

    always_comb begin
        case (r_ch)
            CH_GREEN: w_chan = w_pix.green;
            CH_RED:   w_chan = w_pix.red;
            default:  w_chan = w_pix.blue;
        endcase
    end

    lfbws_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_chan   (w_chan),
        .i_bright (w_pix.bright),
        .o_quot   (w_quot)
    );

    assign w_out_free = !r_out_valid || o_pix_req.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_cmd == CMD_TRANSMIT) n_state = S_READ;
            end
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                n_state = (r_ch == CH_BLUE) ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (w_out_free) n_state = (r_idx == LAST_IDX) ? S_IDLE : S_READ;
            end
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_ram_re    = 1'b0;
        w_mul_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: w_in_ready  = 1'b1;
            S_READ: w_ram_re    = 1'b1;
            S_MUL:  w_mul_start = 1'b1;
            S_DIV:  ;
            S_OUT:  w_load_out  = w_out_free;
        endcase
    end

    assign i_cmd_req.ready = w_in_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sym_one   <= SYM_ONE_RST;
            r_sym_zero  <= SYM_ZERO_RST;
            r_valid     <= '0;
            r_fill      <= '{bright: BRIGHT_RST, red: '0, green: '0, blue: '0};
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_ch        <= CH_GREEN;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SYM_ONE:  r_sym_one  <= i_cfg_data;
                    CFG_SYM_ZERO: r_sym_zero <= i_cfg_data;
                endcase
            end

            if (w_accept) begin
                unique case (w_cmd)
                    CMD_DRAW: begin
                        if (w_draw_ok) r_valid[w_pos[ADDR_W-1:0]] <= 1'b1;
                    end
                    CMD_FILL: begin
                        r_valid <= '0;
                        r_fill  <= w_in_pix;
                    end
                    CMD_CLEAR: begin
                        r_valid <= '0;
                        r_fill  <= '0;
                    end
                    CMD_TRANSMIT: r_idx <= '0;
                endcase
            end

            // channel sequence within a pixel
            if (r_state == S_READ) begin
                r_ch <= CH_GREEN;
            end else if (r_state == S_DIV && r_ch != CH_BLUE) begin
                r_ch <= t_chan'(r_ch + 2'd1);
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
                if (r_idx != LAST_IDX) r_idx <= r_idx + ADDR_W'(1);
            end else if (o_pix_req.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_valid <= r_valid[r_idx];
        end
        if (r_state == S_DIV) begin
            case (r_ch)
                CH_GREEN: r_sg <= w_quot;
                CH_RED:   r_sr <= w_quot;
                default:  r_sb <= w_quot;
            endcase
        end
        if (w_load_out) begin
            r_out.pixel_index   <= r_idx;
            r_out.green_symbols <= expand_byte(r_sg, r_sym_one, r_sym_zero);
            r_out.red_symbols   <= expand_byte(r_sr, r_sym_one, r_sym_zero);
            r_out.blue_symbols  <= expand_byte(r_sb, r_sym_one, r_sym_zero);
            r_out.last_pixel    <= (r_idx == LAST_IDX);
        end
    end

    assign o_pix_req.valid         = r_out_valid;
    assign o_pix_req.pixel_index   = r_out.pixel_index;
    assign o_pix_req.green_symbols = r_out.green_symbols;
    assign o_pix_req.red_symbols   = r_out.red_symbols;
    assign o_pix_req.blue_symbols  = r_out.blue_symbols;
    assign o_pix_req.last_pixel    = r_out.last_pixel;

`ifndef SYNTHESIS
    // a frame walk starts at chain position zero
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == CMD_TRANSMIT) |=> (r_idx == '0 && r_state == S_READ))
        else $error("frame walk did not start at position zero");

    // last flag sits only on the final chain position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last_pixel == (r_out.pixel_index == LAST_IDX)))
        else $error("last_pixel does not match the chain end");

    // walk ends only after the final pixel is loaded
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |-> (w_load_out && r_idx == LAST_IDX))
        else $error("frame walk left before the final pixel");

    // walk index stays inside the chain
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= LAST_IDX))
        else $error("walk index beyond the chain");
`endif
endmodule

// ===== hdl/lfbws_ram.sv =====
`timescale 1ns / 1ps

module lfbws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lfbws_scale.sv =====
`timescale 1ns / 1ps

module lfbws_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lfbws_pkg::CHAN_W-1:0]  i_chan,
    input  logic [lfbws_pkg::CHAN_W-1:0]  i_bright,
    output logic [lfbws_pkg::CHAN_W-1:0]  o_quot
);
    import lfbws_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   w_sum;

    // Multiply, registered
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= i_chan * i_bright;
        end
    end

    // x / 255 for x < 2^16: (x + (x >> 8) + 1) >> 8
    always_comb begin
        w_sum = (PROD_W+1)'(r_prod) + (PROD_W+1)'(r_prod[PROD_W-1:CHAN_W])
              + (PROD_W+1)'(1);
    end

    assign o_quot = w_sum[PROD_W-1:CHAN_W];

`ifndef SYNTHESIS
    // scaling never raises a channel
    a_quot_le_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_quot <= $past(i_chan))
        else $error("scaled channel exceeds its input");

    // full brightness passes the channel through
    a_full_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_bright == BRIGHT_RST) |=> o_quot == $past(i_chan))
        else $error("full brightness altered the channel");

    // zero brightness gives black
    a_zero_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_bright == '0) |=> o_quot == '0)
        else $error("zero brightness gave a nonzero channel");
`endif
endmodule

// ===== tb/sv/led_framebuffer_ws2812_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module led_framebuffer_ws2812_encoder_core_tb;
    import lfbws_pkg::*;

    localparam int COLUMNS   = 8;
    localparam int ROWS      = 8;
    localparam int CHAIN_LEN = (COLUMNS * ROWS > STORE_DEPTH) ? STORE_DEPTH : COLUMNS * ROWS;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfbws_cmd_if cmd_req ();
    lfbws_pix_if pix_req ();

    led_framebuffer_ws2812_encoder_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_req   (cmd_req),
        .o_pix_req   (pix_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow framebuffer and symbol registers
    logic [23:0]            fb_colour [STORE_DEPTH];
    logic [CHAN_W-1:0]      fb_bright [STORE_DEPTH];
    logic [SYMBOL_BITS-1:0] sym_one_q;
    logic [SYMBOL_BITS-1:0] sym_zero_q;

    t_result pending_pixels [$];
    int      errors;
    int      pixels_checked;
    int      cmd_count [4];
    bit      no_gaps;
    int      ready_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("tb: timeout with %0d pixels outstanding", pending_pixels.size());
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, a few long ones; none in a steady stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps) return 0;
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] scale_by(input logic [CHAN_W-1:0] chan,
                                                   input logic [CHAN_W-1:0] bright);
        logic [15:0] prod;
        prod = chan * bright;
        return 8'(prod / 16'd255);
    endfunction

    // Shift in one symbol per bit, MSB first
    function automatic logic [SYMS_W-1:0] to_symbols(input logic [CHAN_W-1:0] v);
        logic [SYMS_W-1:0] acc;
        acc = '0;
        for (int k = CHAN_W - 1; k >= 0; k--)
            acc = {acc[SYMS_W-SYMBOL_BITS-1:0], v[k] ? sym_one_q : sym_zero_q};
        return acc;
    endfunction

    function automatic void set_all(input logic [23:0] colour, input logic [CHAN_W-1:0] bright);
        for (int k = 0; k < STORE_DEPTH; k++) begin
            fb_colour[k] = colour;
            fb_bright[k] = bright;
        end
    endfunction

    // Update the shadow state for one accepted request; queue transmit output
    function automatic void apply_command(input t_cmd kind,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input logic [CHAN_W-1:0] r, g, b, br);
        int      pos;
        t_result px;
        cmd_count[kind]++;
        case (kind)
            CMD_DRAW: begin
                if (col < COLUMNS && row < ROWS) begin
                    // odd rows run right to left
                    pos = row * COLUMNS + (row[0] ? (COLUMNS - 1 - col) : col);
                    if (pos < STORE_DEPTH) begin
                        fb_colour[pos] = {r, g, b};
                        fb_bright[pos] = br;
                    end
                end
            end
            CMD_FILL:  set_all({r, g, b}, br);
            CMD_CLEAR: set_all('0, '0);
            default: begin
                for (int k = 0; k < CHAIN_LEN; k++) begin
                    px.pixel_index   = COORD_W'(k);
                    px.green_symbols = to_symbols(scale_by(fb_colour[k][15:8], fb_bright[k]));
                    px.red_symbols   = to_symbols(scale_by(fb_colour[k][23:16], fb_bright[k]));
                    px.blue_symbols  = to_symbols(scale_by(fb_colour[k][7:0], fb_bright[k]));
                    px.last_pixel    = (k == CHAIN_LEN - 1);
                    pending_pixels.push_back(px);
                end
            end
        endcase
    endfunction

    // One request on the command channel; returns at the accepting edge
    task automatic send_cmd(input t_cmd kind,
                            input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row,
                            input logic [CHAN_W-1:0] r, g, b, br);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_req.valid      <= 1'b1;
        cmd_req.cmd        <= kind;
        cmd_req.column     <= col;
        cmd_req.row        <= row;
        cmd_req.red        <= r;
        cmd_req.green      <= g;
        cmd_req.blue       <= b;
        cmd_req.brightness <= br;
        do @(posedge i_clk); while (!cmd_req.ready);
        apply_command(kind, col, row, r, g, b, br);
    endtask

    task automatic transmit();
        send_cmd(CMD_TRANSMIT, COORD_W'($urandom_range(63)), COORD_W'($urandom_range(63)),
                 CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                 CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)));
    endtask

    // Drop valid, drain all pixels, then let draw/fill/clear finish
    task automatic settle();
        cmd_req.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both symbol registers, back to back
    task automatic set_symbols(input logic [SYMBOL_BITS-1:0] one, input logic [SYMBOL_BITS-1:0] zero);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SYM_ONE;
        i_cfg_data  <= one;
        @(posedge i_clk);
        i_cfg_index <= CFG_SYM_ZERO;
        i_cfg_data  <= zero;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sym_one_q  = one;
        sym_zero_q = zero;
    endtask

    // Result checker
    function automatic void check_field(input string name, input int idx,
                                        input logic [SYMS_W-1:0] want,
                                        input logic [SYMS_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: pixel %0d %s expected %h got %h", $time, idx, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pix_req.valid && pix_req.ready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel expected none got index %0d", $time,
                         pix_req.pixel_index);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                check_field("pixel_index", want.pixel_index, want.pixel_index,
                            pix_req.pixel_index);
                check_field("green_symbols", want.pixel_index, want.green_symbols,
                            pix_req.green_symbols);
                check_field("red_symbols", want.pixel_index, want.red_symbols,
                            pix_req.red_symbols);
                check_field("blue_symbols", want.pixel_index, want.blue_symbols,
                            pix_req.blue_symbols);
                check_field("last_pixel", want.pixel_index, want.last_pixel,
                            pix_req.last_pixel);
            end
        end
    end

    // Output backpressure
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            pix_req.ready <= 1'b0;
        end else begin
            pix_req.ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Frame straight out of reset: black at full brightness
    task automatic test_reset_frame();
        transmit();
    endtask

    // Corners, row reversal, out-of-range coordinates, brightness extremes
    task automatic test_draw_corners();
        send_cmd(CMD_DRAW, 0, 0, 8'hFF, 8'h00, 8'h00, 8'hFF);
        send_cmd(CMD_DRAW, 7, 0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_cmd(CMD_DRAW, 0, 1, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_cmd(CMD_DRAW, 7, 1, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_cmd(CMD_DRAW, 3, 6, 8'hFF, 8'h80, 8'h01, 8'h01);
        send_cmd(CMD_DRAW, 7, 7, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        send_cmd(CMD_DRAW, 2, 5, 8'hA5, 8'h5A, 8'hC3, 8'hFE);
        send_cmd(CMD_DRAW, 8, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_DRAW, 0, 8, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_DRAW, 63, 63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        transmit();
    endtask

    task automatic test_fill_clear();
        send_cmd(CMD_FILL, 63, 63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        transmit();
        send_cmd(CMD_CLEAR, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        transmit();
    endtask

    // Symbol registers at their extremes, then back to the reset values
    task automatic test_symbol_regs();
        send_cmd(CMD_FILL, 0, 0, 8'hA5, 8'h5A, 8'hF0, 8'hFF);
        set_symbols(4'hF, 4'h0);
        transmit();
        set_symbols(4'h0, 4'hF);
        transmit();
        set_symbols(SYM_ONE_RST, SYM_ZERO_RST);
    endtask

    task automatic random_command();
        int                 roll;
        t_cmd               kind;
        logic [COORD_W-1:0] col, row;
        logic [CHAN_W-1:0]  br;
        roll = $urandom_range(99);
        col  = COORD_W'($urandom_range(COLUMNS - 1));
        row  = COORD_W'($urandom_range(ROWS - 1));
        if (roll < 12) begin
            kind = CMD_TRANSMIT;
        end else if (roll < 20) begin
            kind = CMD_FILL;
        end else if (roll < 25) begin
            kind = CMD_CLEAR;
        end else begin
            kind = CMD_DRAW;
        end
        // noise coordinates for non-draw and some out-of-range draws
        if (kind != CMD_DRAW || $urandom_range(99) < 15) begin
            col = COORD_W'($urandom_range(63));
            row = COORD_W'($urandom_range(63));
        end
        roll = $urandom_range(99);
        if (roll < 20)      br = 8'hFF;
        else if (roll < 30) br = 8'h00;
        else                br = CHAN_W'($urandom_range(255));
        send_cmd(kind, col, row, CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                 CHAN_W'($urandom_range(255)), br);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       set_symbols(4'hF, 4'h0);
                2:       set_symbols(4'h0, 4'hF);
                default: set_symbols(SYMBOL_BITS'($urandom_range(15)),
                                     SYMBOL_BITS'($urandom_range(15)));
            endcase
            no_gaps = (phase == 2);
            repeat (50) random_command();
            transmit();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        errors         = 0;
        pixels_checked = 0;
        ready_hold     = 0;
        no_gaps        = 1'b0;
        foreach (cmd_count[k]) cmd_count[k] = 0;
        set_all('0, BRIGHT_RST);
        sym_one_q  = SYM_ONE_RST;
        sym_zero_q = SYM_ZERO_RST;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_SYM_ONE;
        i_cfg_data         <= '0;
        cmd_req.valid      <= 1'b0;
        cmd_req.cmd        <= CMD_DRAW;
        cmd_req.column     <= '0;
        cmd_req.row        <= '0;
        cmd_req.red        <= '0;
        cmd_req.green      <= '0;
        cmd_req.blue       <= '0;
        cmd_req.brightness <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_frame();
        test_draw_corners();
        test_fill_clear();
        test_symbol_regs();
        test_random();
        settle();

        $display("tb: %0d draw, %0d fill, %0d clear, %0d transmit requests; %0d pixels checked",
                 cmd_count[CMD_DRAW], cmd_count[CMD_FILL], cmd_count[CMD_CLEAR],
                 cmd_count[CMD_TRANSMIT], pixels_checked);
        $display("tb: symbol patterns covered reset, both extremes and random settings");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
